[rtl/core/prrj_pkg.sv]
// shared types, register indexes and fixed-point helpers of the reprojection block
package prrj_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CAM_OFF_X = 3'd0;
    localparam logic [2:0] CFG_CAM_OFF_Y = 3'd1;
    localparam logic [2:0] CFG_CAM_OFF_Z = 3'd2;
    localparam logic [2:0] CFG_CAM_ROT_X = 3'd3;
    localparam logic [2:0] CFG_CAM_ROT_Y = 3'd4;
    localparam logic [2:0] CFG_CAM_ROT_Z = 3'd5;
    localparam logic [2:0] CFG_CAM_ROT_W = 3'd6;

    localparam logic [31:0] QUAT_ONE  = 32'h4000_0000;
    localparam int unsigned QUAT_FRAC = 30;

    typedef struct packed {
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] rot_x;
        logic [31:0] rot_y;
        logic [31:0] rot_z;
        logic [31:0] rot_w;
        logic [31:0] obs_u;
        logic [31:0] obs_v;
    } item_t;

    typedef struct packed {
        logic [31:0] err;
        logic [31:0] dfeat_x;
        logic [31:0] dfeat_y;
        logic [31:0] dfeat_z;
        logic [31:0] dpose_0;
        logic [31:0] dpose_1;
        logic [31:0] dpose_2;
        logic [31:0] dpose_3;
        logic [31:0] dpose_4;
        logic [31:0] dpose_5;
        logic        last;
        logic        depth_fault;
    } row_t;

    // row major, entry 3*row+col
    typedef logic [8:0][31:0] mat_t;
    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic signed [34:0] xx;
        logic signed [34:0] yy;
        logic signed [34:0] zz;
        logic signed [34:0] xy;
        logic signed [34:0] xz;
        logic signed [34:0] yz;
        logic signed [34:0] wx;
        logic signed [34:0] wy;
        logic signed [34:0] wz;
    } qprod_t;

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -72'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // round to nearest, ties up
    function automatic logic signed [71:0] rsh(input logic signed [71:0] v,
                                               input int unsigned n);
        logic signed [71:0] half;
        half = 72'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic signed [32:0] sx33(input logic [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [32:0] neg33(input logic [31:0] x);
        return -sx33(x);
    endfunction

    // saturated sum of three rounded products
    function automatic logic [31:0] dot3(input logic signed [32:0] a0,
                                         input logic signed [32:0] b0,
                                         input logic signed [32:0] a1,
                                         input logic signed [32:0] b1,
                                         input logic signed [32:0] a2,
                                         input logic signed [32:0] b2,
                                         input int unsigned n);
        logic signed [71:0] p0;
        logic signed [71:0] p1;
        logic signed [71:0] p2;
        logic signed [71:0] s;
        p0 = a0 * b0;
        p1 = a1 * b1;
        p2 = a2 * b2;
        s  = rsh(p0, n) + rsh(p1, n) + rsh(p2, n);
        return sat32(s);
    endfunction

    function automatic logic signed [34:0] qm(input logic [31:0] a, input logic [31:0] b);
        logic signed [71:0] p;
        logic signed [71:0] r;
        p = sx33(a) * sx33(b);
        r = rsh(p, QUAT_FRAC);
        return 35'(r <<< 1);
    endfunction

    function automatic qprod_t quat_prods(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [31:0] w);
        qprod_t q;
        q.xx = qm(x, x);
        q.yy = qm(y, y);
        q.zz = qm(z, z);
        q.xy = qm(x, y);
        q.xz = qm(x, z);
        q.yz = qm(y, z);
        q.wx = qm(w, x);
        q.wy = qm(w, y);
        q.wz = qm(w, z);
        return q;
    endfunction

    function automatic mat_t rot_mat(input qprod_t q);
        logic signed [71:0] one;
        mat_t m;
        one  = 72'(signed'({1'b0, QUAT_ONE}));
        m[0] = sat32(one - (72'(q.yy) + 72'(q.zz)));
        m[1] = sat32(72'(q.xy) - 72'(q.wz));
        m[2] = sat32(72'(q.xz) + 72'(q.wy));
        m[3] = sat32(72'(q.xy) + 72'(q.wz));
        m[4] = sat32(one - (72'(q.xx) + 72'(q.zz)));
        m[5] = sat32(72'(q.yz) - 72'(q.wx));
        m[6] = sat32(72'(q.xz) - 72'(q.wy));
        m[7] = sat32(72'(q.yz) + 72'(q.wx));
        m[8] = sat32(one - (72'(q.xx) + 72'(q.yy)));
        return m;
    endfunction

    // transposed matrix times vector
    function automatic vec3_t mul_t(input mat_t r, input vec3_t v);
        vec3_t o;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = dot3(sx33(r[i]), sx33(v[0]), sx33(r[3 + i]), sx33(v[1]),
                        sx33(r[6 + i]), sx33(v[2]), QUAT_FRAC);
        end
        return o;
    endfunction

endpackage

[rtl/core/prrj_div.sv]
// pipelined signed divider by a positive divisor, one quotient bit per stage, saturated to 32 bit
module prrj_div #(
    parameter int NW = 49,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [31:0]   den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [31:0]   quo,
    output logic [SW-1:0] side_out
);

    localparam int QW = 32;
    localparam int RW = (NW > 2 * QW) ? NW : 2 * QW;

    logic          v_reg    [QW + 1];
    logic [RW-1:0] rem_reg  [QW + 1];
    logic [QW-1:0] q_reg    [QW + 1];
    logic [31:0]   den_reg  [QW + 1];
    logic          neg_reg  [QW + 1];
    logic          ovf_reg  [QW + 1];
    logic [SW-1:0] side_reg [QW + 1];

    logic [NW-1:0] num_abs;
    logic [RW-1:0] mag_in;
    logic          ovf_in;

    assign num_abs = num[NW-1] ? (~num + NW'(1)) : num;
    assign mag_in  = RW'(num_abs);
    assign ovf_in  = mag_in >= (RW'(den) << QW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= mag_in;
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            neg_reg[0]  <= num[NW-1];
            ovf_reg[0]  <= ovf_in;
            side_reg[0] <= side;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        localparam int B = QW - 1 - s;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(den_reg[s]) << B;
        assign take  = rem_reg[s] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s + 1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s + 1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s + 1]  <= take ? (rem_reg[s] - trial) : rem_reg[s];
                q_reg[s + 1]    <= q_reg[s] | (take ? (QW'(1) << B) : '0);
                den_reg[s + 1]  <= den_reg[s];
                neg_reg[s + 1]  <= neg_reg[s];
                ovf_reg[s + 1]  <= ovf_reg[s];
                side_reg[s + 1] <= side_reg[s];
            end
        end
    end

    logic [QW-1:0] q_fin;
    logic [31:0]   quo_next;

    assign q_fin = q_reg[QW];

    always_comb
    begin
        if (!neg_reg[QW])
        begin
            quo_next = (ovf_reg[QW] || q_fin[QW-1]) ? 32'h7FFF_FFFF : q_fin;
        end
        else
        begin
            quo_next = (ovf_reg[QW] || (q_fin > 32'h8000_0000)) ? 32'h8000_0000
                                                                : (~q_fin + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo      <= quo_next;
            side_out <= side_reg[QW];
        end
    end

endmodule

[rtl/core/point_reprojection_residual_jacobian.sv]
// top level of the point reprojection residual and jacobian pipeline
//
// Each transferred item (world point, body pose, observation) yields two row transfers,
// the u row then the v row (last set). A row carries the residual, the derivative by the
// point and the derivative by position and rotation of the body, all Q16.16 at the default
// FRAC_BITS. The body pose is inverted as a transpose, the camera extrinsic comes from the
// configuration registers (identity at reset). A camera depth under 2^(FRAC_BITS-8) is
// clamped to that value and flags depth_fault on both rows. Both rows of an item share one
// row pipeline and the item holding register frees after the second row enters it, so no new
// item is taken while the v row is still owed. The path holds four front stages (quaternion
// products, matrices, body-frame point, camera-frame point), two 34-stage radix-2 dividers in
// series (projection and inverse depth, then projection over depth), and two jacobian stages.
// The user must write configuration only while the block is empty; the block itself does
// not enforce this.
module point_reprojection_residual_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  prrj_pkg::item_t   item,
    output logic              row_valid,
    input  logic              row_stall,
    output prrj_pkg::row_t    row
);

    // numerator width of the dividers: 32 bit value shifted up by FRAC_BITS, plus sign
    localparam int NW = 33 + FRAC_BITS;
    localparam logic [31:0] MIN_DEPTH = 32'd1 << (FRAC_BITS - 8);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [31:0] cam_off_x_reg;
    logic [31:0] cam_off_y_reg;
    logic [31:0] cam_off_z_reg;
    logic [31:0] cam_rot_x_reg;
    logic [31:0] cam_rot_y_reg;
    logic [31:0] cam_rot_z_reg;
    logic [31:0] cam_rot_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_off_x_reg <= '0;
            cam_off_y_reg <= '0;
            cam_off_z_reg <= '0;
            cam_rot_x_reg <= '0;
            cam_rot_y_reg <= '0;
            cam_rot_z_reg <= '0;
            cam_rot_w_reg <= prrj_pkg::QUAT_ONE;
        end
        else if (cfg_we)
        begin
            // writes beyond the last register are dropped
            unique case (cfg_index)
                prrj_pkg::CFG_CAM_OFF_X: cam_off_x_reg <= cfg_data;
                prrj_pkg::CFG_CAM_OFF_Y: cam_off_y_reg <= cfg_data;
                prrj_pkg::CFG_CAM_OFF_Z: cam_off_z_reg <= cfg_data;
                prrj_pkg::CFG_CAM_ROT_X: cam_rot_x_reg <= cfg_data;
                prrj_pkg::CFG_CAM_ROT_Y: cam_rot_y_reg <= cfg_data;
                prrj_pkg::CFG_CAM_ROT_Z: cam_rot_z_reg <= cfg_data;
                prrj_pkg::CFG_CAM_ROT_W: cam_rot_w_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage payload types
    // ---------------------------------------------------------------
    typedef struct packed {
        prrj_pkg::qprod_t qb;
        prrj_pkg::qprod_t qc;
        prrj_pkg::vec3_t  dv;
        logic [31:0]      obs_u;
        logic [31:0]      obs_v;
    } sa_t;

    typedef struct packed {
        prrj_pkg::mat_t  ri;
        prrj_pkg::mat_t  rc;
        prrj_pkg::vec3_t dv;
        logic [31:0]     obs_u;
        logic [31:0]     obs_v;
    } sb_t;

    typedef struct packed {
        prrj_pkg::mat_t  ri;
        prrj_pkg::mat_t  rc;
        prrj_pkg::vec3_t pimu;
        logic [31:0]     obs_u;
        logic [31:0]     obs_v;
    } sc_t;

    typedef struct packed {
        prrj_pkg::mat_t  ri;
        prrj_pkg::mat_t  rc;
        prrj_pkg::vec3_t pimu;
        prrj_pkg::vec3_t pc;
        logic [31:0]     z;
        logic            fault;
        logic [31:0]     obs_u;
        logic [31:0]     obs_v;
    } sd_t;

    typedef struct packed {
        logic            last;
        logic            fault;
        logic [31:0]     z;
        prrj_pkg::mat_t  ri;
        prrj_pkg::mat_t  rc;
        prrj_pkg::vec3_t pimu;
        logic [31:0]     obs;
    } side1_t;

    typedef struct packed {
        logic            last;
        logic            fault;
        logic [31:0]     recip;
        logic [31:0]     err;
        prrj_pkg::mat_t  ri;
        prrj_pkg::mat_t  rc;
        prrj_pkg::vec3_t pimu;
    } side2_t;

    typedef struct packed {
        logic            last;
        logic            fault;
        logic [31:0]     err;
        prrj_pkg::vec3_t g;
        prrj_pkg::mat_t  ri;
        prrj_pkg::vec3_t pimu;
    } sg_t;

    // ---------------------------------------------------------------
    // flow control: the whole pipe moves when the row register can take a value,
    // the front also waits while the holder still owes its v row
    // ---------------------------------------------------------------
    logic adv;
    logic front_adv;
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic d_valid_reg;
    logic phase_reg;
    logic row_valid_reg;

    assign adv        = !row_valid_reg || !row_stall;
    assign front_adv  = adv && (!d_valid_reg || phase_reg);
    assign item_stall = !front_adv;

    sa_t a_reg, a_next;
    sb_t b_reg;
    sc_t c_reg;
    sd_t d_reg, d_next;

    // stage a: quaternion products and point minus position
    always_comb
    begin
        a_next.qb = prrj_pkg::quat_prods(item.rot_x, item.rot_y, item.rot_z, item.rot_w);
        a_next.qc = prrj_pkg::quat_prods(cam_rot_x_reg, cam_rot_y_reg, cam_rot_z_reg,
                                         cam_rot_w_reg);
        a_next.dv[0] = prrj_pkg::sat32(72'($signed(item.point_x)) - 72'($signed(item.pos_x)));
        a_next.dv[1] = prrj_pkg::sat32(72'($signed(item.point_y)) - 72'($signed(item.pos_y)));
        a_next.dv[2] = prrj_pkg::sat32(72'($signed(item.point_z)) - 72'($signed(item.pos_z)));
        a_next.obs_u = item.obs_u;
        a_next.obs_v = item.obs_v;
    end

    // stage d: camera-frame point and depth clamp
    prrj_pkg::vec3_t t_vec;

    always_comb
    begin
        t_vec[0] = prrj_pkg::sat32(72'($signed(c_reg.pimu[0])) - 72'($signed(cam_off_x_reg)));
        t_vec[1] = prrj_pkg::sat32(72'($signed(c_reg.pimu[1])) - 72'($signed(cam_off_y_reg)));
        t_vec[2] = prrj_pkg::sat32(72'($signed(c_reg.pimu[2])) - 72'($signed(cam_off_z_reg)));
        d_next.ri    = c_reg.ri;
        d_next.rc    = c_reg.rc;
        d_next.pimu  = c_reg.pimu;
        d_next.pc    = prrj_pkg::mul_t(c_reg.rc, t_vec);
        d_next.fault = $signed(d_next.pc[2]) < $signed(MIN_DEPTH);
        d_next.z     = d_next.fault ? MIN_DEPTH : d_next.pc[2];
        d_next.obs_u = c_reg.obs_u;
        d_next.obs_v = c_reg.obs_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            a_valid_reg <= item_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            a_reg       <= a_next;
            b_reg.ri    <= prrj_pkg::rot_mat(a_reg.qb);
            b_reg.rc    <= prrj_pkg::rot_mat(a_reg.qc);
            b_reg.dv    <= a_reg.dv;
            b_reg.obs_u <= a_reg.obs_u;
            b_reg.obs_v <= a_reg.obs_v;
            c_reg.ri    <= b_reg.ri;
            c_reg.rc    <= b_reg.rc;
            c_reg.pimu  <= prrj_pkg::mul_t(b_reg.ri, b_reg.dv);
            c_reg.obs_u <= b_reg.obs_u;
            c_reg.obs_v <= b_reg.obs_v;
            d_reg       <= d_next;
        end
    end

    // row select: 0 while the u row goes out, 1 for the v row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else if (adv && d_valid_reg)
        begin
            phase_reg <= !phase_reg;
        end
    end

    // ---------------------------------------------------------------
    // first divider bank: projection and inverse depth
    // ---------------------------------------------------------------
    logic [31:0]   pc_sel;
    logic [NW-1:0] num_proj;
    logic [NW-1:0] num_recip;
    side1_t        side1_in;
    side1_t        side1_out;
    logic          div1_valid;
    logic [31:0]   proj;
    logic [31:0]   recip;

    assign pc_sel    = phase_reg ? d_reg.pc[1] : d_reg.pc[0];
    assign num_proj  = NW'($signed(pc_sel)) <<< FRAC_BITS;
    assign num_recip = NW'(1) << (2 * FRAC_BITS);

    always_comb
    begin
        side1_in.last  = phase_reg;
        side1_in.fault = d_reg.fault;
        side1_in.z     = d_reg.z;
        side1_in.ri    = d_reg.ri;
        side1_in.rc    = d_reg.rc;
        side1_in.pimu  = d_reg.pimu;
        side1_in.obs   = phase_reg ? d_reg.obs_v : d_reg.obs_u;
    end

    prrj_div #(
        .NW (NW),
        .SW ($bits(side1_t))
    ) u_div_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (num_proj),
        .den       (d_reg.z),
        .side      (side1_in),
        .out_valid (div1_valid),
        .quo       (proj),
        .side_out  (side1_out)
    );

    prrj_div #(
        .NW (NW),
        .SW (1)
    ) u_div_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (num_recip),
        .den       (d_reg.z),
        .side      (1'b0),
        .out_valid (),
        .quo       (recip),
        .side_out  ()
    );

    // ---------------------------------------------------------------
    // second divider: minus projection over depth
    // ---------------------------------------------------------------
    logic [NW-1:0] num_red;
    side2_t        side2_in;
    side2_t        side2_out;
    logic          div2_valid;
    logic [31:0]   red_z;

    assign num_red = -(NW'($signed(proj)) <<< FRAC_BITS);

    always_comb
    begin
        side2_in.last  = side1_out.last;
        side2_in.fault = side1_out.fault;
        side2_in.recip = recip;
        side2_in.err   = prrj_pkg::sat32(72'($signed(proj)) - 72'($signed(side1_out.obs)));
        side2_in.ri    = side1_out.ri;
        side2_in.rc    = side1_out.rc;
        side2_in.pimu  = side1_out.pimu;
    end

    prrj_div #(
        .NW (NW),
        .SW ($bits(side2_t))
    ) u_div_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div1_valid),
        .num       (num_red),
        .den       (side1_out.z),
        .side      (side2_in),
        .out_valid (div2_valid),
        .quo       (red_z),
        .side_out  (side2_out)
    );

    // ---------------------------------------------------------------
    // jacobian stages
    // ---------------------------------------------------------------
    logic [31:0] red_u;
    logic [31:0] red_v;
    sg_t         g_reg, g_next;
    logic        g_valid_reg;

    assign red_u = side2_out.last ? 32'd0 : side2_out.recip;
    assign red_v = side2_out.last ? side2_out.recip : 32'd0;

    always_comb
    begin
        g_next.last  = side2_out.last;
        g_next.fault = side2_out.fault;
        g_next.err   = side2_out.err;
        g_next.ri    = side2_out.ri;
        g_next.pimu  = side2_out.pimu;
        for (int j = 0; j < 3; j++)
        begin
            g_next.g[j] = prrj_pkg::dot3(
                prrj_pkg::sx33(red_u), prrj_pkg::sx33(side2_out.rc[3 * j]),
                prrj_pkg::sx33(red_v), prrj_pkg::sx33(side2_out.rc[3 * j + 1]),
                prrj_pkg::sx33(red_z), prrj_pkg::sx33(side2_out.rc[3 * j + 2]),
                prrj_pkg::QUAT_FRAC);
        end
    end

    prrj_pkg::vec3_t feat;
    prrj_pkg::row_t  row_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            feat[j] = prrj_pkg::dot3(
                prrj_pkg::sx33(g_reg.g[0]), prrj_pkg::sx33(g_reg.ri[3 * j]),
                prrj_pkg::sx33(g_reg.g[1]), prrj_pkg::sx33(g_reg.ri[3 * j + 1]),
                prrj_pkg::sx33(g_reg.g[2]), prrj_pkg::sx33(g_reg.ri[3 * j + 2]),
                prrj_pkg::QUAT_FRAC);
        end
        row_next.err     = g_reg.err;
        row_next.dfeat_x = feat[0];
        row_next.dfeat_y = feat[1];
        row_next.dfeat_z = feat[2];
        row_next.dpose_0 = prrj_pkg::sat32(-72'($signed(feat[0])));
        row_next.dpose_1 = prrj_pkg::sat32(-72'($signed(feat[1])));
        row_next.dpose_2 = prrj_pkg::sat32(-72'($signed(feat[2])));
        // g times the skew matrix of the body-frame point, zero terms dropped
        row_next.dpose_3 = prrj_pkg::dot3(
            prrj_pkg::sx33(g_reg.g[0]), 33'sd0,
            prrj_pkg::sx33(g_reg.g[1]), prrj_pkg::sx33(g_reg.pimu[2]),
            prrj_pkg::sx33(g_reg.g[2]), prrj_pkg::neg33(g_reg.pimu[1]),
            FRAC_BITS);
        row_next.dpose_4 = prrj_pkg::dot3(
            prrj_pkg::sx33(g_reg.g[0]), prrj_pkg::neg33(g_reg.pimu[2]),
            prrj_pkg::sx33(g_reg.g[1]), 33'sd0,
            prrj_pkg::sx33(g_reg.g[2]), prrj_pkg::sx33(g_reg.pimu[0]),
            FRAC_BITS);
        row_next.dpose_5 = prrj_pkg::dot3(
            prrj_pkg::sx33(g_reg.g[0]), prrj_pkg::sx33(g_reg.pimu[1]),
            prrj_pkg::sx33(g_reg.g[1]), prrj_pkg::neg33(g_reg.pimu[0]),
            prrj_pkg::sx33(g_reg.g[2]), 33'sd0,
            FRAC_BITS);
        row_next.last        = g_reg.last;
        row_next.depth_fault = g_reg.fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg   <= 1'b0;
            row_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg   <= div2_valid;
            row_valid_reg <= g_valid_reg;
        end
    end

    prrj_pkg::row_t row_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg   <= g_next;
            row_reg <= row_next;
        end
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // the holder keeps its item for the v row after sending the u row
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !phase_reg && adv |=> d_valid_reg && phase_reg)
        else $error("item left the holder before its v row");

    // no new item while the v row is still owed
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !phase_reg |-> item_stall)
        else $error("item transfer while the holder is busy");

    // the divisor is never below the depth floor
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> ($signed(d_reg.z) >= $signed(MIN_DEPTH)))
        else $error("depth below the floor reached the dividers");

endmodule
